/* sv/acsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package acsm_pkg;

    localparam int MAX_SITES_DEF  = 4096;
    localparam int COORD_BITS_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic [7:0] TOL_RESET = 8'd5;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_ORDER = 2'd2;

    localparam logic REG_STRAND_MATCH = 1'b0;
    localparam logic REG_TOLERANCE    = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] query_position;
        logic               query_reverse;
        logic [FIELD_W-1:0] entry_left;
        logic [FIELD_W-1:0] entry_right;
        logic               entry_reverse;
    } t_acsm_item;

    typedef struct packed {
        logic [FIELD_W-1:0] clip_length;
        logic [1:0]         status;
    } t_acsm_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

/* sv/amplicon_clip_site_match.sv */
`timescale 1ns / 1ps
`default_nettype none

// Amplicon clip site matcher. Pulse start while busy is low to hand in one beat;
// exactly one result beat follows on o_result, marked by o_result_valid for one
// cycle, and it cannot be held off. Clear, load and the unused action code give
// their result in the cycle after the accept and leave busy low. A query keeps
// busy high while the binary search runs down a chain of clog2(MAX_SITES)
// cells, each with its own copy of the right ends, and while the forward scan
// then reads one table entry a cycle from the table memory until the reach test
// or the table end stops it. The result shows up in the first cycle busy is low
// again. Loads must come in ascending right order. Configuration goes through
// the APB port while idle: a rule for the user that the block does not enforce.
module amplicon_clip_site_match import acsm_pkg::*; #(
    parameter int MAX_SITES  = MAX_SITES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire t_acsm_item            i_item,
    output logic                       busy,
    output logic                       o_result_valid,
    output t_acsm_result               o_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    localparam int CNT_W   = $clog2(MAX_SITES+1);
    localparam int IDX_W   = $clog2(MAX_SITES);
    localparam int NCELL   = IDX_W;
    localparam int REACH_W = COORD_BITS + 2;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [COORD_BITS-1:0] r_span;
    logic [COORD_BITS-1:0] r_last_right;
    logic                  r_strand_match;
    logic [7:0]            r_tol;
    logic [COORD_BITS-1:0] r_pos;
    logic                  r_rev;
    logic [COORD_BITS-1:0] r_key;
    logic [REACH_W-1:0]    r_reach;
    logic                  r_res_valid;
    logic                  n_res_valid;
    t_acsm_result          r_res;
    t_acsm_result          n_res;

    logic                  w_accept;
    logic                  w_cfg_wr;
    logic [COORD_BITS-1:0] w_pos;
    logic [COORD_BITS-1:0] w_left;
    logic [COORD_BITS-1:0] w_right;
    logic [COORD_BITS-1:0] w_tol;
    logic [COORD_BITS-1:0] w_key;
    logic [REACH_W-1:0]    w_reach;
    logic [COORD_BITS-1:0] w_span;
    logic                  w_full;
    logic                  w_order;
    logic                  w_load_ok;
    logic [IDX_W-1:0]      w_wr_addr;
    logic                  w_scan_start;
    logic                  w_scan_done;
    logic [COORD_BITS-1:0] w_scan_clip;

    logic                  w_cvalid [0:NCELL];
    logic [CNT_W-1:0]      w_clo    [0:NCELL];
    logic [CNT_W-1:0]      w_chi    [0:NCELL];
    logic [CNT_W-1:0]      w_cmid   [0:NCELL];

    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_STRAND_MATCH: prdata = {31'b0, r_strand_match};
            REG_TOLERANCE:    prdata = {24'b0, r_tol};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strand_match <= 1'b0;
            r_tol          <= TOL_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_STRAND_MATCH) begin
                r_strand_match <= pwdata[0];
            end else begin
                r_tol <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        w_pos     = COORD_BITS'(i_item.query_position);
        w_left    = COORD_BITS'(i_item.entry_left);
        w_right   = COORD_BITS'(i_item.entry_right);
        w_tol     = COORD_BITS'(r_tol);
        if (i_item.query_reverse) begin
            w_key = (w_pos > w_tol) ? (w_pos - w_tol) : '0;
        end else begin
            w_key = w_pos;
        end
        w_reach   = REACH_W'(w_pos) + REACH_W'(r_span) + REACH_W'(r_tol);
        w_span    = (w_right > w_left) ? (w_right - w_left) : '0;
        w_full    = (r_count == CNT_W'(MAX_SITES));
        w_order   = (r_count != '0) && (w_right < r_last_right);
        w_load_ok = w_accept && (i_item.action == ACT_LOAD) && !w_full && !w_order;
        w_wr_addr = r_count[IDX_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_item.action == ACT_QUERY)) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_cvalid[NCELL]) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy         = 1'b1;
        w_scan_start = 1'b0;
        unique case (r_state)
            ST_IDLE:   busy = 1'b0;
            ST_SEARCH: w_scan_start = w_cvalid[NCELL];
            ST_SCAN:   busy = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

    always_comb begin
        n_res_valid = 1'b0;
        n_res       = r_res;
        priority if (w_accept && (i_item.action != ACT_QUERY)) begin
            n_res_valid       = 1'b1;
            n_res.clip_length = '0;
            n_res.status      = STS_OK;
            if (i_item.action == ACT_LOAD) begin
                if (w_full) begin
                    n_res.status = STS_FULL;
                end else if (w_order) begin
                    n_res.status = STS_ORDER;
                end
            end
        end else if (w_scan_done) begin
            n_res_valid       = 1'b1;
            n_res.clip_length = FIELD_W'(w_scan_clip);
            n_res.status      = STS_OK;
        end else begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_span      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (w_accept && (i_item.action == ACT_CLEAR)) begin
                r_count <= '0;
                r_span  <= '0;
            end else if (w_load_ok) begin
                r_count <= r_count + CNT_W'(1);
                if (w_span > r_span) begin
                    r_span <= w_span;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_accept) begin
            r_pos   <= w_pos;
            r_rev   <= i_item.query_reverse;
            r_key   <= w_key;
            r_reach <= w_reach;
        end
        if (w_load_ok) begin
            r_last_right <= w_right;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    // search chain: first cell is fed straight from the accepted beat
    assign w_cvalid[0] = w_accept && (i_item.action == ACT_QUERY);
    assign w_clo[0]    = '0;
    assign w_chi[0]    = r_count;
    assign w_cmid[0]   = r_count >> 1;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        acsm_cell #(
            .MAX_SITES (MAX_SITES),
            .COORD_BITS(COORD_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_cvalid[k]),
            .i_lo     (w_clo[k]),
            .i_hi     (w_chi[k]),
            .i_mid    (w_cmid[k]),
            .i_key    (r_key),
            .i_wr_en  (w_load_ok),
            .i_wr_addr(w_wr_addr),
            .i_wr_data(w_right),
            .o_valid  (w_cvalid[k+1]),
            .o_lo     (w_clo[k+1]),
            .o_hi     (w_chi[k+1]),
            .o_mid    (w_cmid[k+1])
        );
    end

    acsm_scan #(
        .MAX_SITES (MAX_SITES),
        .COORD_BITS(COORD_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_scan_start),
        .i_lo          (w_clo[NCELL]),
        .i_count       (r_count),
        .i_pos         (r_pos),
        .i_rev         (r_rev),
        .i_reach       (r_reach),
        .i_tol         (r_tol),
        .i_strand_match(r_strand_match),
        .i_wr_en       (w_load_ok),
        .i_wr_addr     (w_wr_addr),
        .i_wr_left     (w_left),
        .i_wr_right    (w_right),
        .i_wr_strand   (i_item.entry_reverse),
        .o_done        (w_scan_done),
        .o_clip        (w_scan_clip)
    );

endmodule

`default_nettype wire

/* sv/acsm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module acsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* sv/acsm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// one step of the binary search; owns a copy of the right ends
module acsm_cell import acsm_pkg::*; #(
    parameter int MAX_SITES  = MAX_SITES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [$clog2(MAX_SITES+1)-1:0]   i_lo,
    input  wire logic [$clog2(MAX_SITES+1)-1:0]   i_hi,
    input  wire logic [$clog2(MAX_SITES+1)-1:0]   i_mid,
    input  wire logic [COORD_BITS-1:0]            i_key,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(MAX_SITES)-1:0]     i_wr_addr,
    input  wire logic [COORD_BITS-1:0]            i_wr_data,
    output logic                                  o_valid,
    output logic      [$clog2(MAX_SITES+1)-1:0]   o_lo,
    output logic      [$clog2(MAX_SITES+1)-1:0]   o_hi,
    output logic      [$clog2(MAX_SITES+1)-1:0]   o_mid
);

    localparam int CNT_W = $clog2(MAX_SITES+1);
    localparam int IDX_W = $clog2(MAX_SITES);

    logic             r_valid;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_hi;
    logic [CNT_W-1:0] r_mid;
    logic [COORD_BITS-1:0] w_right;
    logic [CNT_W-1:0] w_diff;
    logic             w_active;
    logic             w_below;
    logic [CNT_W:0]   w_sum;

    acsm_ram #(
        .WIDTH(COORD_BITS),
        .DEPTH(MAX_SITES)
    ) u_right (
        .i_clk    (i_clk),
        .i_wr_en  (i_wr_en),
        .i_wr_addr(i_wr_addr),
        .i_wr_data(i_wr_data),
        .i_rd_addr(i_mid[IDX_W-1:0]),
        .o_rd_data(w_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= i_lo;
        r_hi  <= i_hi;
        r_mid <= i_mid;
    end

    always_comb begin
        w_diff   = r_hi - r_lo;
        w_active = (w_diff > CNT_W'(1));
        w_below  = (w_right <= i_key);
        o_lo     = (w_active && w_below) ? r_mid : r_lo;
        o_hi     = (w_active && !w_below) ? r_mid : r_hi;
        w_sum    = {1'b0, o_lo} + {1'b0, o_hi};
        o_mid    = w_sum[CNT_W:1];
        o_valid  = r_valid;
    end

endmodule

`default_nettype wire

/* sv/acsm_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

// forward scan from the search result, one entry a cycle
module acsm_scan import acsm_pkg::*; #(
    parameter int MAX_SITES  = MAX_SITES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [$clog2(MAX_SITES+1)-1:0]   i_lo,
    input  wire logic [$clog2(MAX_SITES+1)-1:0]   i_count,
    input  wire logic [COORD_BITS-1:0]            i_pos,
    input  wire logic                             i_rev,
    input  wire logic [COORD_BITS+1:0]            i_reach,
    input  wire logic [7:0]                       i_tol,
    input  wire logic                             i_strand_match,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(MAX_SITES)-1:0]     i_wr_addr,
    input  wire logic [COORD_BITS-1:0]            i_wr_left,
    input  wire logic [COORD_BITS-1:0]            i_wr_right,
    input  wire logic                             i_wr_strand,
    output logic                                  o_done,
    output logic      [COORD_BITS-1:0]            o_clip
);

    localparam int CNT_W  = $clog2(MAX_SITES+1);
    localparam int IDX_W  = $clog2(MAX_SITES);
    localparam int WORD_W = 2 * COORD_BITS + 1;

    logic                  r_run;
    logic                  r_pend;
    logic [CNT_W-1:0]      r_idx;
    logic [COORD_BITS-1:0] r_best;

    logic [WORD_W-1:0]     w_word;
    logic [COORD_BITS-1:0] w_left;
    logic [COORD_BITS-1:0] w_right;
    logic                  w_strand;
    logic [COORD_BITS-1:0] w_tol;
    logic [COORD_BITS-1:0] w_wl;
    logic [COORD_BITS:0]   w_wr;
    logic [COORD_BITS-1:0] w_got;
    logic                  w_skip;
    logic                  w_brk;
    logic                  w_hit;
    logic                  w_stop;
    logic                  w_issue;
    logic [COORD_BITS-1:0] n_best;

    acsm_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_SITES)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (i_wr_en),
        .i_wr_addr(i_wr_addr),
        .i_wr_data({i_wr_left, i_wr_right, i_wr_strand}),
        .i_rd_addr(r_idx[IDX_W-1:0]),
        .o_rd_data(w_word)
    );

    always_comb begin
        w_left   = w_word[WORD_W-1 -: COORD_BITS];
        w_right  = w_word[COORD_BITS:1];
        w_strand = w_word[0];
        w_tol    = COORD_BITS'(i_tol);
        // window widened by the tolerance on the side the read comes from
        if (i_rev) begin
            w_wl  = w_left;
            w_wr  = {1'b0, w_right} + {1'b0, w_tol};
            w_got = i_pos - w_left;
        end else begin
            w_wl  = (w_left > w_tol) ? (w_left - w_tol) : '0;
            w_wr  = {1'b0, w_right};
            w_got = w_right - i_pos;
        end
        w_skip  = i_strand_match && (w_strand != i_rev);
        w_brk   = r_pend && !w_skip && (i_reach < {1'b0, w_wr});
        w_hit   = r_pend && !w_skip && !w_brk && (i_pos >= w_wl)
                  && ({1'b0, i_pos} <= w_wr);
        n_best  = (w_hit && (w_got > r_best)) ? w_got : r_best;
        w_stop  = r_run && (w_brk || (r_idx >= i_count));
        w_issue = r_run && !w_stop;
        o_done  = w_stop;
        o_clip  = n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_pend <= 1'b0;
        end else begin
            r_run  <= w_issue;
            r_pend <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx  <= i_lo;
            r_best <= '0;
        end else begin
            if (w_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            r_best <= n_best;
        end
    end

endmodule

`default_nettype wire

/* dv/amplicon_clip_site_match_tb.sv */
`timescale 1ns / 1ps

module amplicon_clip_site_match_tb;
    import acsm_pkg::*;

    localparam int     SITE_DEPTH    = MAX_SITES_DEF;
    localparam int     STALL_LIMIT   = 20000;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     TAIL_CYCLES   = 30;
    localparam int     RANDOM_BEATS  = 860;
    localparam longint COORD_MAX     = 64'hFFFF_FFFF;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_STRAND =
        APB_ADDR_W'(4 * int'(REG_STRAND_MATCH));
    localparam logic [APB_ADDR_W-1:0] ADDR_TOL =
        APB_ADDR_W'(4 * int'(REG_TOLERANCE));

    typedef enum logic [1:0] {
        OP_BEAT,
        OP_CFG_WRITE,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind              kind;
        t_acsm_item            item;
        logic [APB_ADDR_W-1:0] addr;
        logic [31:0]           data;
    } t_op;

    typedef enum logic [1:0] {
        DRV_RUN,
        DRV_SETTLE,
        DRV_SETUP,
        DRV_ACCESS
    } t_drv_phase;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    t_acsm_item            i_item  = '0;
    logic                  busy;
    logic                  o_result_valid;
    t_acsm_result          o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state
    logic [31:0] mdl_left   [SITE_DEPTH];
    logic [31:0] mdl_right  [SITE_DEPTH];
    logic        mdl_strand [SITE_DEPTH];
    int unsigned mdl_count;
    logic [31:0] mdl_span;
    logic        mdl_strand_match;
    logic [7:0]  mdl_tol;

    // stimulus-side view of the table, used only to aim loads and queries
    logic [31:0] gen_left  [SITE_DEPTH];
    logic [31:0] gen_right [SITE_DEPTH];
    int          gen_count;
    logic [7:0]  gen_tol;
    int unsigned meaningful_beats;

    t_op          op_backlog[$];
    t_acsm_result clip_due[$];

    t_drv_phase   drv_phase   = DRV_RUN;
    int unsigned  gap_left    = 0;
    int unsigned  settle_left = 0;
    logic         start_nx;
    logic         no_idle     = 1'b0;
    t_acsm_result mon_due;
    int unsigned  stall_cycles = 0;
    int unsigned  fail_count   = 0;

    amplicon_clip_site_match uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clip_for_read(logic [31:0] pos, logic rev);
        longint unsigned p, tol, key, reach, wl, wr, best, got;
        int unsigned     lo, hi, mid, i;
        p    = pos;
        tol  = mdl_tol;
        best = 0;
        if (!rev) begin
            key = p;
        end else if (p > tol) begin
            key = p - tol;
        end else begin
            key = 0;
        end
        reach = p + mdl_span + tol;
        lo    = 0;
        hi    = mdl_count;
        mid   = mdl_count / 2;
        while (hi - lo > 1) begin
            if (mdl_right[mid] <= key) begin
                lo = mid;
            end else begin
                hi = mid;
            end
            mid = (lo + hi) / 2;
        end
        for (i = lo; i < mdl_count; i++) begin
            if (mdl_strand_match && mdl_strand[i] != rev) continue;
            // widen the end that faces the read
            if (rev) begin
                wl = mdl_left[i];
                wr = mdl_right[i] + tol;
            end else begin
                wl = (mdl_left[i] > tol) ? mdl_left[i] - tol : 0;
                wr = mdl_right[i];
            end
            if (reach < wr) break;
            if (p >= wl && p <= wr) begin
                got = rev ? p - mdl_left[i] : mdl_right[i] - p;
                if (got > best) best = got;
            end
        end
        return best[31:0];
    endfunction

    function automatic t_acsm_result clip_outcome(t_acsm_item it);
        t_acsm_result r;
        logic [31:0]  span;
        r = '0;
        case (it.action)
            ACT_CLEAR: begin
                mdl_count = 0;
                mdl_span  = '0;
            end
            ACT_LOAD: begin
                if (mdl_count >= SITE_DEPTH) begin
                    r.status = STS_FULL;
                end else if (mdl_count > 0 && it.entry_right < mdl_right[mdl_count - 1]) begin
                    r.status = STS_ORDER;
                end else begin
                    span = (it.entry_right > it.entry_left) ?
                           it.entry_right - it.entry_left : '0;
                    mdl_left[mdl_count]   = it.entry_left;
                    mdl_right[mdl_count]  = it.entry_right;
                    mdl_strand[mdl_count] = it.entry_reverse;
                    mdl_count++;
                    if (span > mdl_span) mdl_span = span;
                end
            end
            ACT_QUERY: r.clip_length = clip_for_read(it.query_position, it.query_reverse);
            default: ;
        endcase
        return r;
    endfunction

    function automatic void apply_register(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
        if (addr == ADDR_STRAND) begin
            mdl_strand_match = data[0];
        end else if (addr == ADDR_TOL) begin
            mdl_tol = data[7:0];
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if ($urandom_range(0, 99) < 2) no_idle = !no_idle;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_acsm_item noise_item();
        t_acsm_item it;
        it.action         = 2'($urandom_range(0, 3));
        it.query_position = $urandom;
        it.query_reverse  = 1'($urandom_range(0, 1));
        it.entry_left     = $urandom;
        it.entry_right    = $urandom;
        it.entry_reverse  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic queue_beat(t_acsm_item it);
        t_op op;
        op.kind = OP_BEAT;
        op.item = it;
        op.addr = '0;
        op.data = '0;
        op_backlog.push_back(op);
        if (it.action != ACT_UNUSED) meaningful_beats++;
        if (it.action == ACT_CLEAR) begin
            gen_count = 0;
        end else if (it.action == ACT_LOAD && gen_count < SITE_DEPTH &&
                     (gen_count == 0 || it.entry_right >= gen_right[gen_count - 1])) begin
            gen_left[gen_count]  = it.entry_left;
            gen_right[gen_count] = it.entry_right;
            gen_count++;
        end
    endtask

    task automatic queue_simple(logic [1:0] act);
        t_acsm_item it;
        it        = noise_item();
        it.action = act;
        queue_beat(it);
    endtask

    task automatic queue_load(logic [31:0] left, logic [31:0] right, logic strand);
        t_acsm_item it;
        it               = noise_item();
        it.action        = ACT_LOAD;
        it.entry_left    = left;
        it.entry_right   = right;
        it.entry_reverse = strand;
        queue_beat(it);
    endtask

    task automatic queue_query(logic [31:0] pos, logic rev);
        t_acsm_item it;
        it                = noise_item();
        it.action         = ACT_QUERY;
        it.query_position = pos;
        it.query_reverse  = rev;
        queue_beat(it);
    endtask

    task automatic queue_cfg(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
        t_op op;
        op.kind = OP_CFG_WRITE;
        op.item = '0;
        op.addr = addr;
        op.data = data;
        op_backlog.push_back(op);
    endtask

    task automatic queue_drain();
        t_op op;
        op.kind = OP_DRAIN;
        op.item = '0;
        op.addr = '0;
        op.data = '0;
        op_backlog.push_back(op);
    endtask

    // unused upper bits carry junk so the register masking gets exercised
    task automatic set_config(logic strand_only, logic [7:0] tol);
        queue_cfg(ADDR_STRAND, ($urandom & 32'hFFFF_FFFE) | 32'(strand_only));
        queue_cfg(ADDR_TOL, ($urandom & 32'hFFFF_FF00) | 32'(tol));
        gen_tol = tol;
    endtask

    function automatic logic [31:0] near_site();
        longint      p, w;
        int unsigned j;
        if (gen_count == 0 || $urandom_range(0, 9) == 0) return $urandom;
        j = $urandom_range(0, gen_count - 1);
        w = longint'(gen_tol) + 8;
        case ($urandom_range(0, 3))
            0: p = longint'(gen_left[j]) + longint'($urandom_range(0, 2 * w)) - w;
            1: p = longint'(gen_right[j]) + longint'($urandom_range(0, 2 * w)) - w;
            2: p = longint'(gen_left[j]) + longint'($urandom_range(0, 600));
            default: p = longint'(gen_right[j]) - longint'($urandom_range(0, 600));
        endcase
        if (p < 0) p = 0;
        if (p > COORD_MAX) p = COORD_MAX;
        return p[31:0];
    endfunction

    // mostly ascending loads, with a few out-of-order or wild ones mixed in
    task automatic queue_table(int unsigned n_loads, logic [31:0] base);
        longint      cur, lft;
        logic [31:0] below;
        cur = longint'(base);
        repeat (n_loads) begin
            if (gen_count != 0 && longint'(gen_right[gen_count - 1]) > cur)
                cur = longint'(gen_right[gen_count - 1]);
            case ($urandom_range(0, 24))
                0: queue_load($urandom, $urandom, 1'($urandom_range(0, 1)));
                1: begin
                    below = cur[31:0];
                    if (below != 0) below = below - 1;
                    queue_load($urandom, $urandom_range(0, below), 1'($urandom_range(0, 1)));
                end
                default: begin
                    if ($urandom_range(0, 9) != 0) cur = cur + longint'($urandom_range(1, 300));
                    if (cur > COORD_MAX) cur = COORD_MAX;
                    case ($urandom_range(0, 19))
                        0: lft = cur - longint'($urandom);
                        1: lft = cur + longint'($urandom_range(1, 500));
                        default: lft = cur - longint'($urandom_range(0, 400));
                    endcase
                    if (lft < 0) lft = 0;
                    if (lft > COORD_MAX) lft = COORD_MAX;
                    queue_load(lft[31:0], cur[31:0], 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_phase = DRV_RUN;
            gap_left  = 0;
        end else begin
            start_nx = 1'b0;
            if (start && !busy) begin
                clip_due.push_back(clip_outcome(i_item));
                void'(op_backlog.pop_front());
                gap_left = pick_gap();
            end
            case (drv_phase)
                DRV_RUN: begin
                    if (op_backlog.size() != 0) begin
                        if (op_backlog[0].kind != OP_BEAT) begin
                            drv_phase   = DRV_SETTLE;
                            settle_left = SETTLE_CYCLES;
                        end else if (gap_left != 0) begin
                            gap_left--;
                        end else begin
                            start_nx = 1'b1;
                            i_item   <= op_backlog[0].item;
                        end
                    end
                end
                DRV_SETTLE: begin
                    // hold off until every outstanding beat has come back
                    if (clip_due.size() != 0 || busy || o_result_valid) begin
                        settle_left = SETTLE_CYCLES;
                    end else if (settle_left != 0) begin
                        settle_left--;
                    end else if (op_backlog[0].kind == OP_DRAIN) begin
                        void'(op_backlog.pop_front());
                        drv_phase = DRV_RUN;
                    end else begin
                        psel      <= 1'b1;
                        pwrite    <= 1'b1;
                        penable   <= 1'b0;
                        paddr     <= op_backlog[0].addr;
                        pwdata    <= op_backlog[0].data;
                        drv_phase = DRV_SETUP;
                    end
                end
                DRV_SETUP: begin
                    penable   <= 1'b1;
                    drv_phase = DRV_ACCESS;
                end
                DRV_ACCESS: begin
                    if (pready) begin
                        apply_register(op_backlog[0].addr, op_backlog[0].data);
                        void'(op_backlog.pop_front());
                        psel      <= 1'b0;
                        penable   <= 1'b0;
                        pwrite    <= 1'b0;
                        drv_phase = DRV_RUN;
                    end
                end
                default: drv_phase = DRV_RUN;
            endcase
            start <= start_nx;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (clip_due.size() == 0) begin
                $error("result beat with nothing outstanding: clip_length %0d, status %0d",
                       o_result.clip_length, o_result.status);
                fail_count++;
            end else begin
                mon_due = clip_due.pop_front();
                if (o_result.clip_length !== mon_due.clip_length) begin
                    $error("clip_length: expected %0d, actual %0d",
                           mon_due.clip_length, o_result.clip_length);
                    fail_count++;
                end
                if (o_result.status !== mon_due.status) begin
                    $error("status: expected %0d, actual %0d", mon_due.status, o_result.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid ||
            (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned n_loads, n_queries, target;
        logic [31:0] base;
        logic [7:0]  tol;

        mdl_count        = 0;
        mdl_span         = '0;
        mdl_strand_match = 1'b0;
        mdl_tol          = TOL_RESET;
        gen_count        = 0;
        gen_tol          = TOL_RESET;
        meaningful_beats = 0;

        // directed
        queue_query(32'h0000_1234, 1'b0);
        queue_simple(ACT_UNUSED);
        queue_load(32'd0, 32'd100, 1'b0);
        queue_load(32'd50, 32'd100, 1'b1);
        queue_load(32'd200, 32'd90, 1'b0);
        queue_load(32'd300, 32'd250, 1'b1);
        queue_load(32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b0);
        queue_query(32'd0, 1'b0);
        queue_query(32'd2, 1'b0);
        queue_query(32'd3, 1'b1);
        queue_query(32'd102, 1'b1);
        queue_query(32'd260, 1'b1);
        queue_query(32'hFFFF_FFFF, 1'b1);
        queue_query(32'hFFFF_FFF0, 1'b0);
        queue_load(32'd0, 32'hFFFF_FFFF, 1'b1);
        queue_query(32'hFFFF_FFFF, 1'b0);
        queue_query(32'd40, 1'b1);
        set_config(1'b1, 8'd0);
        queue_query(32'd100, 1'b1);
        queue_query(32'd0, 1'b0);
        queue_query(32'd250, 1'b1);
        set_config(1'b0, 8'd255);
        queue_query(32'd200, 1'b0);
        queue_query(32'd10, 1'b1);
        queue_query(32'hFFFF_FFFF, 1'b1);
        queue_simple(ACT_CLEAR);
        queue_query(32'd50, 1'b0);
        set_config(1'b0, TOL_RESET);

        // random episodes: optional reconfig, optional drain, usually a clear, a table, then queries against it
        target = meaningful_beats + RANDOM_BEATS;
        while (meaningful_beats < target) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0: tol = 8'd0;
                    1: tol = 8'd255;
                    2: tol = 8'($urandom_range(0, 255));
                    default: tol = 8'($urandom_range(0, 20));
                endcase
                set_config(1'($urandom_range(0, 1)), tol);
            end
            if ($urandom_range(0, 9) == 0) queue_drain();
            if ($urandom_range(0, 4) != 0) queue_simple(ACT_CLEAR);
            n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                                                    $urandom_range(1, 30);
            case ($urandom_range(0, 4))
                0: base = 32'd0;
                1: base = 32'hFFFF_FFFF - $urandom_range(0, 20000);
                default: base = $urandom_range(0, 32'hF000_0000);
            endcase
            queue_table(n_loads, base);
            n_queries = $urandom_range(4, 30);
            repeat (n_queries) begin
                case ($urandom_range(0, 19))
                    0: queue_beat(noise_item());
                    1: queue_simple(ACT_UNUSED);
                    2: queue_table(1, 32'd0);
                    default: queue_query(near_site(), 1'($urandom_range(0, 1)));
                endcase
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((op_backlog.size() != 0 || clip_due.size() != 0) && stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no beat moved for %0d cycles, %0d results outstanding",
                   STALL_LIMIT, clip_due.size());
            fail_count++;
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* amplicon_clip_site_match.f */
sv/acsm_pkg.sv
sv/acsm_ram.sv
sv/acsm_cell.sv
sv/acsm_scan.sv
sv/amplicon_clip_site_match.sv
dv/amplicon_clip_site_match_tb.sv
